### rtl/cfjs_pkg.sv
package cfjs_pkg;

  localparam int MODE_W   = 2;
  localparam int JOB_W    = 4;
  localparam int DRV_W    = 3;
  localparam int UNIT_W   = 5;
  localparam int STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_UNIT  = 2'd1,
    MODE_GRANT = 2'd2,
    MODE_REL   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_GRANTED = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_REFUSED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    J_FREE   = 2'd0,
    J_WAIT   = 2'd1,
    J_ACTIVE = 2'd2
  } jstat_t;

  // Operation applied to the mask word that arrives in the cycle after its read.
  typedef enum logic [1:0] {
    P_NONE  = 2'd0,
    P_CHECK = 2'd1,
    P_SET   = 2'd2,
    P_CLEAR = 2'd3
  } pop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_UNIT_RD,
    S_UNIT_WR,
    S_SCAN,
    S_SCAN_END,
    S_GRANT,
    S_GRANT_END,
    S_REL,
    S_REL_END
  } state_t;

endpackage

### rtl/conflict_free_job_scheduler_top.sv
// Conflict-free job scheduler. A request is taken when start is high and busy is low; exactly
// one result follows, shown for a single cycle with out_valid high, and the receiver cannot
// stall it. The per-driver unit masks of every job live in one single-port memory with a
// registered read, and add, release and grant walk that memory one driver word per cycle, with
// MAX_DRIVERS words per job: add zeroes the new job's masks, add-unit reads one word and
// writes it back, release clears the job's units from the busy map, and a grant checks the
// waiting jobs in turn until one is runnable, then marks its units busy, or answers blocked.
// Refused requests and a grant with nothing waiting answer in the cycle after acceptance.
module conflict_free_job_scheduler_top #(
  parameter int MAX_JOBS         = 16,
  parameter int MAX_DRIVERS      = 8,
  parameter int UNITS_PER_DRIVER = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [cfjs_pkg::MODE_W-1:0]     in_mode,
  input  logic [cfjs_pkg::JOB_W-1:0]      in_job_id,
  input  logic [cfjs_pkg::DRV_W-1:0]      in_driver_index,
  input  logic [cfjs_pkg::UNIT_W-1:0]     in_unit_number,
  output logic                            out_valid,
  output logic [cfjs_pkg::STATUS_W-1:0]   out_status,
  output logic [cfjs_pkg::JOB_W-1:0]      out_granted_job
);
  import cfjs_pkg::*;

  localparam int JW         = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int DW         = (MAX_DRIVERS > 1) ? $clog2(MAX_DRIVERS) : 1;
  localparam int CW         = $clog2(MAX_JOBS + 1);
  localparam int UW         = UNITS_PER_DRIVER;
  localparam int MASK_DEPTH = MAX_JOBS * MAX_DRIVERS;
  localparam int AW         = $clog2(MASK_DEPTH);

  state_t           state_r, state_nxt;
  pop_t             p_op_r, p_op_nxt;
  logic [DW-1:0]    p_d_r;
  logic [JW-1:0]    job_r;
  logic [DW-1:0]    drv_r;
  logic [UNIT_W-1:0] unit_r;
  logic [DW-1:0]    d_r;
  logic [JW-1:0]    i_r;
  logic [CW-1:0]    cnt_r;
  logic             conflict_r, any_r;
  logic [JW-1:0]    order_r [MAX_JOBS];
  jstat_t           jstat_r [MAX_JOBS];
  logic [UW-1:0]    busy_r  [MAX_DRIVERS];
  logic             out_valid_r;
  status_t          out_status_r, out_status_nxt;
  logic [JOB_W-1:0] out_job_r, out_job_nxt;
  logic             out_fire;

  logic [UW-1:0]    mask_mem [MASK_DEPTH];
  logic [UW-1:0]    mem_rdata_r;
  logic [UW-1:0]    mem_wdata;
  logic [AW-1:0]    mem_addr;
  logic [JW-1:0]    mem_job;
  logic [DW-1:0]    mem_drv;
  logic             mem_we;

  mode_t            req_mode;
  logic [JW-1:0]    req_job;
  jstat_t           req_stat;
  logic             req_job_ok, add_ok, unit_ok, rel_ok;
  logic             acc_fire, last_d, last_i;
  logic             hit, nonzero, conflict_all, any_all, runnable;
  logic [JW-1:0]    scan_job;
  logic             add_commit, grant_take, rel_commit, sweep_step;

  // Request decode.
  assign req_mode   = mode_t'(in_mode);
  assign req_job    = JW'(in_job_id);
  assign req_job_ok = ({28'd0, in_job_id} < 32'(MAX_JOBS));
  assign req_stat   = jstat_r[req_job];
  assign add_ok     = (req_stat == J_FREE) && (cnt_r < CW'(MAX_JOBS));
  assign unit_ok    = (req_stat == J_WAIT) &&
                      ({29'd0, in_driver_index} < 32'(MAX_DRIVERS)) &&
                      ({27'd0, in_unit_number} < 32'(UNITS_PER_DRIVER));
  assign rel_ok     = (req_stat == J_ACTIVE);
  assign acc_fire   = start && (state_r == S_IDLE);

  assign last_d   = (d_r == DW'(MAX_DRIVERS - 1));
  assign last_i   = ((CW'(i_r) + CW'(1)) == cnt_r);
  assign scan_job = order_r[i_r];

  // Overlap test on the mask word returned by the memory this cycle.
  assign hit          = (p_op_r == P_CHECK) && ((mem_rdata_r & busy_r[p_d_r]) != '0);
  assign nonzero      = (p_op_r == P_CHECK) && (mem_rdata_r != '0);
  assign conflict_all = conflict_r | hit;
  assign any_all      = any_r | nonzero;
  assign runnable     = any_all && !conflict_all;

  assign add_commit = (state_r == S_CLR) && last_d;
  assign grant_take = (state_r == S_SCAN_END) && runnable;
  assign rel_commit = (state_r == S_REL_END);
  assign sweep_step = ((state_r == S_CLR) || (state_r == S_SCAN) ||
                       (state_r == S_GRANT) || (state_r == S_REL)) && !last_d;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (req_mode)
            MODE_GRANT: state_nxt = (cnt_r == '0) ? S_IDLE : S_SCAN;
            MODE_ADD:   state_nxt = (req_job_ok && add_ok) ? S_CLR : S_IDLE;
            MODE_UNIT:  state_nxt = (req_job_ok && unit_ok) ? S_UNIT_RD : S_IDLE;
            MODE_REL:   state_nxt = (req_job_ok && rel_ok) ? S_REL : S_IDLE;
          endcase
        end
      end
      S_CLR:       state_nxt = last_d ? S_IDLE : S_CLR;
      S_UNIT_RD:   state_nxt = S_UNIT_WR;
      S_UNIT_WR:   state_nxt = S_IDLE;
      S_SCAN:      state_nxt = last_d ? S_SCAN_END : S_SCAN;
      S_SCAN_END: begin
        if (runnable) begin
          state_nxt = S_GRANT;
        end else begin
          state_nxt = last_i ? S_IDLE : S_SCAN;
        end
      end
      S_GRANT:     state_nxt = last_d ? S_GRANT_END : S_GRANT;
      S_GRANT_END: state_nxt = S_IDLE;
      S_REL:       state_nxt = last_d ? S_REL_END : S_REL;
      S_REL_END:   state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Memory controls, read pipeline and result.
  always_comb begin
    mem_job        = job_r;
    mem_drv        = d_r;
    mem_we         = 1'b0;
    mem_wdata      = mem_rdata_r | (UW'(1) << unit_r);
    p_op_nxt       = P_NONE;
    out_fire       = 1'b0;
    out_status_nxt = ST_DONE;
    out_job_nxt    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (req_mode)
            MODE_GRANT: begin
              out_fire       = (cnt_r == '0);
              out_status_nxt = ST_EMPTY;
            end
            MODE_ADD: begin
              out_fire       = !(req_job_ok && add_ok);
              out_status_nxt = ST_REFUSED;
            end
            MODE_UNIT: begin
              out_fire       = !(req_job_ok && unit_ok);
              out_status_nxt = ST_REFUSED;
            end
            MODE_REL: begin
              out_fire       = !(req_job_ok && rel_ok);
              out_status_nxt = ST_REFUSED;
            end
          endcase
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        out_fire  = last_d;
      end
      S_UNIT_RD: begin
        mem_drv = drv_r;
      end
      S_UNIT_WR: begin
        mem_drv  = drv_r;
        mem_we   = 1'b1;
        out_fire = 1'b1;
      end
      S_SCAN: begin
        mem_job  = scan_job;
        p_op_nxt = P_CHECK;
      end
      S_SCAN_END: begin
        out_fire       = !runnable && last_i;
        out_status_nxt = ST_BLOCKED;
      end
      S_GRANT: begin
        p_op_nxt = P_SET;
      end
      S_GRANT_END: begin
        out_fire       = 1'b1;
        out_status_nxt = ST_GRANTED;
        out_job_nxt    = JOB_W'(job_r);
      end
      S_REL: begin
        p_op_nxt = P_CLEAR;
      end
      S_REL_END: begin
        out_fire = 1'b1;
      end
      default: ;
    endcase
    mem_addr = AW'(mem_job) * AW'(MAX_DRIVERS) + AW'(mem_drv);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mask_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_op_r      <= P_NONE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int k = 0; k < MAX_JOBS; k++) begin
        jstat_r[k] <= J_FREE;
      end
      for (int k = 0; k < MAX_DRIVERS; k++) begin
        busy_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      p_op_r      <= p_op_nxt;
      out_valid_r <= out_fire;
      unique case (p_op_r)
        P_SET:   busy_r[p_d_r] <= busy_r[p_d_r] | mem_rdata_r;
        P_CLEAR: busy_r[p_d_r] <= busy_r[p_d_r] & ~mem_rdata_r;
        P_NONE, P_CHECK: ;
      endcase
      if (add_commit) begin
        cnt_r          <= cnt_r + CW'(1);
        jstat_r[job_r] <= J_WAIT;
      end
      if (grant_take) begin
        cnt_r             <= cnt_r - CW'(1);
        jstat_r[scan_job] <= J_ACTIVE;
      end
      if (rel_commit) begin
        jstat_r[job_r] <= J_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_d_r <= d_r;
    if (acc_fire) begin
      job_r      <= req_job;
      drv_r      <= DW'(in_driver_index);
      unit_r     <= in_unit_number;
      d_r        <= '0;
      i_r        <= '0;
      conflict_r <= 1'b0;
      any_r      <= 1'b0;
    end else begin
      if (sweep_step) begin
        d_r <= d_r + DW'(1);
      end
      // One waiting job has been fully checked: take it or move to the next one.
      if (state_r == S_SCAN_END) begin
        conflict_r <= 1'b0;
        any_r      <= 1'b0;
        d_r        <= '0;
        if (runnable) begin
          job_r <= scan_job;
        end else begin
          i_r <= i_r + JW'(1);
        end
      end else if (p_op_r == P_CHECK) begin
        conflict_r <= conflict_all;
        any_r      <= any_all;
      end
    end
    // The newest job goes to the head; a granted job closes its gap.
    if (add_commit) begin
      order_r[0] <= job_r;
      for (int k = 1; k < MAX_JOBS; k++) begin
        order_r[k] <= order_r[k-1];
      end
    end
    if (grant_take) begin
      for (int k = 0; k < MAX_JOBS - 1; k++) begin
        if (JW'(k) >= i_r) begin
          order_r[k] <= order_r[k+1];
        end
      end
    end
    if (out_fire) begin
      out_status_r <= out_status_nxt;
      out_job_r    <= out_job_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_granted_job = out_job_r;

endmodule

### dv/testbench.sv
module testbench;
  import cfjs_pkg::*;

  localparam int JOBS           = 16;
  localparam int DRIVERS        = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct {
    status_t    status;
    logic [3:0] job;
  } reply_t;

  class sched_scoreboard;
    jstat_t      job_state [JOBS];
    logic [3:0]  wait_queue [$];
    logic [31:0] unit_mask [JOBS][DRIVERS];
    logic [31:0] busy_map [DRIVERS];
    reply_t      expected_replies [$];
    int          mismatches;

    function new();
      for (int j = 0; j < JOBS; j++) begin
        job_state[j] = J_FREE;
        for (int d = 0; d < DRIVERS; d++) unit_mask[j][d] = '0;
      end
      for (int d = 0; d < DRIVERS; d++) busy_map[d] = '0;
      mismatches = 0;
    endfunction

    // A job with no units at all is treated as blocked.
    function bit job_can_run(logic [3:0] j);
      bit any_unit;
      bit clash;
      any_unit = 0;
      clash = 0;
      for (int d = 0; d < DRIVERS; d++) begin
        if (unit_mask[j][d] != 0) any_unit = 1;
        if ((unit_mask[j][d] & busy_map[d]) != 0) clash = 1;
      end
      return any_unit && !clash;
    endfunction

    function bit pick_job(jstat_t want, output logic [3:0] j);
      logic [3:0] candidates [$];
      for (int k = 0; k < JOBS; k++)
        if (job_state[k] == want) candidates.push_back(4'(k));
      j = '0;
      if (candidates.size() == 0) return 0;
      j = candidates[$urandom_range(candidates.size() - 1)];
      return 1;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(mode_t m, logic [3:0] j, logic [2:0] d, logic [4:0] u);
      reply_t r;
      bit     found;
      logic [3:0] pick;
      r.status = ST_DONE;
      r.job    = '0;
      found    = 0;
      case (m)
        MODE_GRANT: begin
          if (wait_queue.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_BLOCKED;
            for (int i = 0; i < wait_queue.size() && !found; i++) begin
              if (job_can_run(wait_queue[i])) begin
                found = 1;
                pick = wait_queue[i];
                wait_queue.delete(i);
                for (int k = 0; k < DRIVERS; k++) busy_map[k] |= unit_mask[pick][k];
                job_state[pick] = J_ACTIVE;
                r.status = ST_GRANTED;
                r.job = pick;
              end
            end
          end
        end
        MODE_ADD: begin
          if (job_state[j] != J_FREE || wait_queue.size() >= JOBS) begin
            r.status = ST_REFUSED;
          end else begin
            wait_queue.push_front(j);
            for (int k = 0; k < DRIVERS; k++) unit_mask[j][k] = '0;
            job_state[j] = J_WAIT;
          end
        end
        MODE_UNIT: begin
          if (job_state[j] != J_WAIT) r.status = ST_REFUSED;
          else unit_mask[j][d][u] = 1'b1;
        end
        default: begin
          if (job_state[j] != J_ACTIVE) begin
            r.status = ST_REFUSED;
          end else begin
            for (int k = 0; k < DRIVERS; k++) busy_map[k] &= ~unit_mask[j][k];
            job_state[j] = J_FREE;
          end
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [2:0] status, logic [3:0] job);
      reply_t e;
      if (expected_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none expected, expected none, got status %0d job %0d",
                 $time, status, job);
        return;
      end
      e = expected_replies.pop_front();
      if (status !== e.status) begin
        mismatches++;
        $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, status);
      end
      if (job !== e.job) begin
        mismatches++;
        $display("%0t: granted job mismatch, expected %0d, got %0d", $time, e.job, job);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   in_mode = '0;
  logic [JOB_W-1:0]    in_job_id = '0;
  logic [DRV_W-1:0]    in_driver_index = '0;
  logic [UNIT_W-1:0]   in_unit_number = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [JOB_W-1:0]    out_granted_job;

  sched_scoreboard sb;
  int quiet_cycles = 0;

  conflict_free_job_scheduler_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_job_id      (in_job_id),
    .in_driver_index(in_driver_index),
    .in_unit_number (in_unit_number),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_granted_job(out_granted_job)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_reply(out_status, out_granted_job);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(mode_t m, logic [3:0] j, logic [2:0] d, logic [4:0] u);
    start           <= 1'b1;
    in_mode         <= m;
    in_job_id       <= j;
    in_driver_index <= d;
    in_unit_number  <= u;
    do @(posedge clk); while (busy);
    sb.note_request(m, j, d, u);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly coherent traffic: add free slots, fill waiting jobs with a few units from a
  // narrow range so that conflicts are common, grant, and release active jobs.
  task automatic send_random(int pct);
    int         r;
    mode_t      m;
    logic [3:0] j;
    logic [2:0] d;
    logic [4:0] u;
    r = $urandom_range(99);
    m = mode_t'($urandom_range(3));
    j = 4'($urandom_range(15));
    d = 3'($urandom_range(7));
    u = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
    if (r >= 12) begin
      if (r < 35) begin
        m = MODE_ADD;
        void'(sb.pick_job(J_FREE, j));
      end else if (r < 65) begin
        m = MODE_UNIT;
        void'(sb.pick_job(J_WAIT, j));
      end else if (r < 82) begin
        m = MODE_GRANT;
      end else begin
        m = MODE_REL;
        void'(sb.pick_job(J_ACTIVE, j));
      end
    end
    send_request(m, j, d, u);
    sender_gap(pct);
  endtask

  task automatic run_directed();
    send_request(MODE_GRANT, 4'($urandom_range(15)), 3'($urandom_range(7)),
                 5'($urandom_range(31)));
    send_request(MODE_REL, 4'd3, 3'd0, 5'd0);
    send_request(MODE_UNIT, 4'd3, 3'd1, 5'd1);
    send_request(MODE_ADD, 4'd0, 3'd7, 5'd31);
    send_request(MODE_ADD, 4'd0, 3'd0, 5'd0);
    // The only waiting job has no units yet.
    send_request(MODE_GRANT, 4'd15, 3'd7, 5'd31);
    send_request(MODE_UNIT, 4'd0, 3'd0, 5'd0);
    send_request(MODE_UNIT, 4'd0, 3'd0, 5'd0);
    send_request(MODE_UNIT, 4'd0, 3'd7, 5'd31);
    send_request(MODE_ADD, 4'd15, 3'd2, 5'd17);
    send_request(MODE_UNIT, 4'd15, 3'd7, 5'd31);
    send_request(MODE_UNIT, 4'd15, 3'd5, 5'd10);
    send_request(MODE_ADD, 4'd9, 3'd0, 5'd0);
    send_request(MODE_GRANT, 4'd0, 3'd0, 5'd0);
    send_request(MODE_GRANT, 4'd0, 3'd0, 5'd0);
    send_request(MODE_REL, 4'd0, 3'd4, 5'd8);
    send_request(MODE_UNIT, 4'd15, 3'd1, 5'd2);
    send_request(MODE_REL, 4'd15, 3'd6, 5'd21);
    send_request(MODE_GRANT, 4'd5, 3'd5, 5'd5);
    send_request(MODE_UNIT, 4'd9, 3'd3, 5'd16);
    send_request(MODE_GRANT, 4'd0, 3'd0, 5'd0);
    send_request(MODE_ADD, 4'd9, 3'd0, 5'd0);
    send_request(MODE_REL, 4'd9, 3'd1, 5'd30);
    send_request(MODE_REL, 4'd0, 3'd0, 5'd0);
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain_replies();
    repeat (150) send_random(11);
    drain_replies();
    repeat (150) send_random(77);
    drain_replies();
    repeat (150) send_random(0);
    start <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < WATCHDOG_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("[FAIL] regression broken");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (sb.mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
